// ===== sv/dco_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dco_pkg
// shared constants, register map, request codes and control structs for the
// direct 2d convolution output core
// ============================================================================
package dco_pkg;

    // store sizing
    localparam int MAX_SRC_DIM = 64;
    localparam int MAX_IN_CH   = 4;
    localparam int MAX_OUT_CH  = 16;
    localparam int MAX_KERNEL  = 11;
    localparam int STRIDE_MAX  = 16;

    localparam int SRC_DEPTH = MAX_IN_CH * MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;

    localparam int SRC_AW  = $clog2(SRC_DEPTH);
    localparam int WGT_AW  = $clog2(WGT_DEPTH);
    localparam int BIAS_AW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int KC_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int IC_W    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;

    // transaction field widths
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 14;
    localparam int VAL_W  = 16;
    localparam int OC_W   = 4;
    localparam int POS_W  = 6;
    localparam int SUM_W  = 42;
    localparam int PROD_W = 2 * VAL_W;

    // register widths
    localparam int DIM_W    = 7;
    localparam int ICN_W    = 3;
    localparam int OCN_W    = 5;
    localparam int KER_W    = 4;
    localparam int STR_W    = 5;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 3;

    // register indexes
    localparam logic [REGIDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_OUT_CHANNELS = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_KERNEL_H     = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_KERNEL_W     = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_STRIDE_V     = 3'd6;
    localparam logic [REGIDX_W-1:0] REG_STRIDE_H     = 3'd7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LD_SRC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LD_WGT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LD_BIAS = 2'd2;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd3;

    // clamped configuration
    typedef struct packed {
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [ICN_W-1:0] ic_n;
        logic [OCN_W-1:0] oc_n;
        logic [KER_W-1:0] kh;
        logic [KER_W-1:0] kw;
        logic [STR_W-1:0] sv;
        logic [STR_W-1:0] sh;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic wr_src;
        logic wr_wgt;
        logic wr_bias;
        logic capture;
        logic prep1;
        logic prep2;
        logic init;
        logic issue;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic last_tap;
        logic pipe_busy;
    } t_stat;

endpackage

// ===== sv/dco_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dco_ram
// generic single write port, single read port ram with registered read
// ============================================================================
module dco_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dco_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dco_ctrl
// sequencer: loads, position check, tap loop and result issue
// ============================================================================
module dco_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dco_pkg::REQ_W-1:0] i_req_type,
    input  dco_pkg::t_stat            i_stat,
    output dco_pkg::t_cmd             o_cmd,
    output logic                      o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP1 = 3'd1;
    localparam logic [2:0] S_PREP2 = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        dco_pkg::REQ_LD_SRC:  o_cmd.wr_src  = 1'b1;
                        dco_pkg::REQ_LD_WGT:  o_cmd.wr_wgt  = 1'b1;
                        dco_pkg::REQ_LD_BIAS: o_cmd.wr_bias = 1'b1;
                        dco_pkg::REQ_COMPUTE: begin
                            o_cmd.capture = 1'b1;
                            n_state       = S_PREP1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/dco_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dco_dp
// datapath: sample, weight and bias stores, address walk, shared mac and
// result register
// ============================================================================
module dco_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dco_pkg::t_cmd              i_cmd,
    input  dco_pkg::t_cfg              i_cfg,
    input  logic [dco_pkg::ADDR_W-1:0] i_address,
    input  logic [dco_pkg::VAL_W-1:0]  i_value,
    input  logic [dco_pkg::OC_W-1:0]   i_out_channel,
    input  logic [dco_pkg::POS_W-1:0]  i_out_row,
    input  logic [dco_pkg::POS_W-1:0]  i_out_col,
    output dco_pkg::t_stat             o_stat,
    output logic                       o_valid,
    output logic [dco_pkg::SUM_W-1:0]  o_out_sum,
    output logic                       o_bad_request
);

    localparam int OFS_W   = dco_pkg::POS_W + dco_pkg::STR_W;
    localparam int PLANE_W = 2 * dco_pkg::DIM_W - 1;
    localparam int KK_W    = 2 * dco_pkg::KER_W - 1;
    localparam int OCIC_W  = dco_pkg::OC_W + dco_pkg::ICN_W;
    localparam int ROWM_W  = OFS_W + dco_pkg::DIM_W;
    localparam int WBM_W   = OCIC_W + KK_W;
    localparam int CMP_W   = OFS_W + 1;
    localparam int SUM_W   = dco_pkg::SUM_W;
    localparam int VAL_W   = dco_pkg::VAL_W;
    localparam int PROD_W  = dco_pkg::PROD_W;
    localparam int SRC_AW  = dco_pkg::SRC_AW;
    localparam int WGT_AW  = dco_pkg::WGT_AW;

    // captured request
    logic [dco_pkg::OC_W-1:0]  r_oc;
    logic [dco_pkg::POS_W-1:0] r_orow;
    logic [dco_pkg::POS_W-1:0] r_ocol;

    // set-up products
    logic [OFS_W-1:0]   r_row0;
    logic [OFS_W-1:0]   r_col0;
    logic [PLANE_W-1:0] r_plane;
    logic [KK_W-1:0]    r_kk;
    logic [OCIC_W-1:0]  r_ocic;
    logic [SRC_AW-1:0]  r_rowoff;
    logic [WGT_AW-1:0]  r_wbase;
    logic               r_bad_pos;

    // address walk
    logic [SRC_AW-1:0]          r_src_ptr;
    logic [SRC_AW-1:0]          r_row_ptr;
    logic [SRC_AW-1:0]          r_ic_ptr;
    logic [WGT_AW-1:0]          r_wgt_ptr;
    logic [dco_pkg::KC_W-1:0]   r_c;
    logic [dco_pkg::KC_W-1:0]   r_r;
    logic [dco_pkg::IC_W-1:0]   r_ic;
    logic [SRC_AW-1:0]          n_src_ptr;
    logic [SRC_AW-1:0]          n_row_ptr;
    logic [SRC_AW-1:0]          n_ic_ptr;
    logic [dco_pkg::KC_W-1:0]   n_c;
    logic [dco_pkg::KC_W-1:0]   n_r;
    logic [dco_pkg::IC_W-1:0]   n_ic;
    logic                       c_end;
    logic                       r_end;
    logic                       ic_end;
    logic [SRC_AW-1:0]          plane_ext;
    logic [SRC_AW-1:0]          width_ext;

    // mac pipeline
    logic                       r_v1;
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]           r_acc;

    // result register
    logic                       r_valid;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_bad;

    // store ports
    logic                       src_we;
    logic                       wgt_we;
    logic                       bias_we;
    logic [VAL_W-1:0]           src_q;
    logic [VAL_W-1:0]           wgt_q;
    logic [VAL_W-1:0]           bias_q;

    assign src_we  = i_cmd.wr_src && (32'(i_address) < 32'(dco_pkg::SRC_DEPTH));
    assign wgt_we  = i_cmd.wr_wgt && (32'(i_address) < 32'(dco_pkg::WGT_DEPTH));
    assign bias_we = i_cmd.wr_bias && (32'(i_address) < 32'(dco_pkg::MAX_OUT_CH));

    dco_ram #(.WIDTH(VAL_W), .DEPTH(dco_pkg::SRC_DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (i_address[SRC_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_src_ptr),
        .o_rdata (src_q)
    );

    dco_ram #(.WIDTH(VAL_W), .DEPTH(dco_pkg::WGT_DEPTH)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (i_address[WGT_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_wgt_ptr),
        .o_rdata (wgt_q)
    );

    dco_ram #(.WIDTH(VAL_W), .DEPTH(dco_pkg::MAX_OUT_CH)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (bias_we),
        .i_waddr (i_address[dco_pkg::BIAS_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_oc[dco_pkg::BIAS_AW-1:0]),
        .o_rdata (bias_q)
    );

    // request capture and set-up products
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_oc   <= i_out_channel;
            r_orow <= i_out_row;
            r_ocol <= i_out_col;
        end
        if (i_cmd.prep1) begin
            r_row0  <= OFS_W'(r_orow) * OFS_W'(i_cfg.sv);
            r_col0  <= OFS_W'(r_ocol) * OFS_W'(i_cfg.sh);
            r_plane <= PLANE_W'(i_cfg.src_w) * PLANE_W'(i_cfg.src_h);
            r_kk    <= KK_W'(i_cfg.kh) * KK_W'(i_cfg.kw);
            r_ocic  <= OCIC_W'(r_oc) * OCIC_W'(i_cfg.ic_n);
        end
        if (i_cmd.prep2) begin
            r_rowoff  <= SRC_AW'(ROWM_W'(r_row0) * ROWM_W'(i_cfg.src_w));
            r_wbase   <= WGT_AW'(WBM_W'(r_ocic) * WBM_W'(r_kk));
            // output channel must be in range and the window must fit inside the source plane
            r_bad_pos <= ({1'b0, r_oc} >= i_cfg.oc_n)
                      || ((CMP_W'(r_row0) + CMP_W'(i_cfg.kh)) > CMP_W'(i_cfg.src_h))
                      || ((CMP_W'(r_col0) + CMP_W'(i_cfg.kw)) > CMP_W'(i_cfg.src_w));
        end
    end

    // tap walk: weights are contiguous, samples step by column, row and plane
    assign plane_ext = SRC_AW'(r_plane);
    assign width_ext = SRC_AW'(i_cfg.src_w);
    assign c_end  = (r_c == (i_cfg.kw - 1'b1));
    assign r_end  = (r_r == (i_cfg.kh - 1'b1));
    assign ic_end = (r_ic == dco_pkg::IC_W'(i_cfg.ic_n - 1'b1));

    always_comb begin
        n_c       = r_c + 1'b1;
        n_r       = r_r;
        n_ic      = r_ic;
        n_src_ptr = r_src_ptr + 1'b1;
        n_row_ptr = r_row_ptr;
        n_ic_ptr  = r_ic_ptr;
        if (c_end) begin
            n_c = '0;
            if (r_end) begin
                n_r       = '0;
                n_ic      = r_ic + 1'b1;
                n_ic_ptr  = r_ic_ptr + plane_ext;
                n_row_ptr = r_ic_ptr + plane_ext;
                n_src_ptr = r_ic_ptr + plane_ext;
            end else begin
                n_r       = r_r + 1'b1;
                n_row_ptr = r_row_ptr + width_ext;
                n_src_ptr = r_row_ptr + width_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_src_ptr <= r_rowoff + SRC_AW'(r_col0);
            r_row_ptr <= r_rowoff + SRC_AW'(r_col0);
            r_ic_ptr  <= r_rowoff + SRC_AW'(r_col0);
            r_wgt_ptr <= r_wbase;
            r_c       <= '0;
            r_r       <= '0;
            r_ic      <= '0;
        end else if (i_cmd.issue) begin
            r_src_ptr <= n_src_ptr;
            r_row_ptr <= n_row_ptr;
            r_ic_ptr  <= n_ic_ptr;
            r_wgt_ptr <= r_wgt_ptr + 1'b1;
            r_c       <= n_c;
            r_r       <= n_r;
            r_ic      <= n_ic;
        end
    end

    // shared mac: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= $signed(src_q) * $signed(wgt_q);
        end
        if (i_cmd.init) begin
            r_acc <= {{(SUM_W - VAL_W - 8){bias_q[VAL_W-1]}}, bias_q, 8'h00};
        end else if (r_v2) begin
            r_acc <= r_acc + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sum <= r_bad_pos ? '0 : r_acc;
            r_bad <= r_bad_pos;
        end
    end

    assign o_stat.bad       = r_bad_pos;
    assign o_stat.last_tap  = c_end && r_end && ic_end;
    assign o_stat.pipe_busy = r_v1 || r_v2;

    assign o_valid       = r_valid;
    assign o_out_sum     = r_sum;
    assign o_bad_request = r_bad;

endmodule

// ===== sv/direct_conv2d_output_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// direct_conv2d_output_core
// direct multichannel 2d convolution, one output position per transaction
// ============================================================================
// A transaction is taken when start is high and busy is low. Load transactions
// (sample, weight, bias) write their store in the cycle they are taken, raise
// no busy and give no result, so one load can be taken every cycle. A compute
// transaction holds busy through its set-up steps, then the kernel taps one
// at a time through the single shared multiply-accumulate unit (one sample and
// one weight read per cycle from the stores), then the drain of the read and
// multiply stages. A position outside the output plane, or an output channel
// out of range, drops busy after the set-up steps instead. The result strobe
// o_valid is high for exactly one cycle, in the first cycle after busy falls;
// there is no back-pressure on the result, so the receiver must take it in that
// cycle. Configuration must be written over the apb port only while no compute
// transaction is in flight; the block itself does not enforce this. Register
// values out of range are saturated into their legal range when used.
// ============================================================================
module direct_conv2d_output_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [dco_pkg::REQ_W-1:0]    i_req_type,
    input  logic [dco_pkg::ADDR_W-1:0]   i_address,
    input  logic [dco_pkg::VAL_W-1:0]    i_value,
    input  logic [dco_pkg::OC_W-1:0]     i_out_channel,
    input  logic [dco_pkg::POS_W-1:0]    i_out_row,
    input  logic [dco_pkg::POS_W-1:0]    i_out_col,
    // result channel
    output logic                         o_valid,
    output logic [dco_pkg::SUM_W-1:0]    o_out_sum,
    output logic                         o_bad_request,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dco_pkg::PADDR_W-1:0]  paddr,
    input  logic [dco_pkg::PDATA_W-1:0]  pwdata,
    output logic [dco_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // raw register file, reset to the documented defaults
    logic [dco_pkg::DIM_W-1:0] r_src_width;
    logic [dco_pkg::DIM_W-1:0] r_src_height;
    logic [dco_pkg::ICN_W-1:0] r_in_channels;
    logic [dco_pkg::OCN_W-1:0] r_out_channels;
    logic [dco_pkg::KER_W-1:0] r_kernel_h;
    logic [dco_pkg::KER_W-1:0] r_kernel_w;
    logic [dco_pkg::STR_W-1:0] r_stride_v;
    logic [dco_pkg::STR_W-1:0] r_stride_h;

    logic                           cfg_wr;
    logic [dco_pkg::REGIDX_W-1:0]   reg_idx;
    dco_pkg::t_cfg                  cfg;
    dco_pkg::t_cmd                  cmd;
    dco_pkg::t_stat                 stat;

    // saturate into [1, hi]
    function automatic logic [7:0] clamp_reg(input logic [7:0] v, input logic [7:0] hi);
        logic [7:0] res;
        if (v == 8'd0) begin
            res = 8'd1;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // word-aligned map, low address bits ignored
    assign reg_idx = paddr[dco_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= dco_pkg::DIM_W'(64);
            r_src_height   <= dco_pkg::DIM_W'(64);
            r_in_channels  <= dco_pkg::ICN_W'(1);
            r_out_channels <= dco_pkg::OCN_W'(1);
            r_kernel_h     <= dco_pkg::KER_W'(3);
            r_kernel_w     <= dco_pkg::KER_W'(3);
            r_stride_v     <= dco_pkg::STR_W'(1);
            r_stride_h     <= dco_pkg::STR_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                dco_pkg::REG_SRC_WIDTH:    r_src_width    <= pwdata[dco_pkg::DIM_W-1:0];
                dco_pkg::REG_SRC_HEIGHT:   r_src_height   <= pwdata[dco_pkg::DIM_W-1:0];
                dco_pkg::REG_IN_CHANNELS:  r_in_channels  <= pwdata[dco_pkg::ICN_W-1:0];
                dco_pkg::REG_OUT_CHANNELS: r_out_channels <= pwdata[dco_pkg::OCN_W-1:0];
                dco_pkg::REG_KERNEL_H:     r_kernel_h     <= pwdata[dco_pkg::KER_W-1:0];
                dco_pkg::REG_KERNEL_W:     r_kernel_w     <= pwdata[dco_pkg::KER_W-1:0];
                dco_pkg::REG_STRIDE_V:     r_stride_v     <= pwdata[dco_pkg::STR_W-1:0];
                dco_pkg::REG_STRIDE_H:     r_stride_h     <= pwdata[dco_pkg::STR_W-1:0];
                default: ;
            endcase
        end
    end

    // read back the raw values
    always_comb begin
        case (reg_idx)
            dco_pkg::REG_SRC_WIDTH:    prdata = dco_pkg::PDATA_W'(r_src_width);
            dco_pkg::REG_SRC_HEIGHT:   prdata = dco_pkg::PDATA_W'(r_src_height);
            dco_pkg::REG_IN_CHANNELS:  prdata = dco_pkg::PDATA_W'(r_in_channels);
            dco_pkg::REG_OUT_CHANNELS: prdata = dco_pkg::PDATA_W'(r_out_channels);
            dco_pkg::REG_KERNEL_H:     prdata = dco_pkg::PDATA_W'(r_kernel_h);
            dco_pkg::REG_KERNEL_W:     prdata = dco_pkg::PDATA_W'(r_kernel_w);
            dco_pkg::REG_STRIDE_V:     prdata = dco_pkg::PDATA_W'(r_stride_v);
            dco_pkg::REG_STRIDE_H:     prdata = dco_pkg::PDATA_W'(r_stride_h);
            default:                   prdata = '0;
        endcase
    end

    // saturated view used by the datapath, zero behaves as one
    always_comb begin
        cfg.src_w = dco_pkg::DIM_W'(clamp_reg(8'(r_src_width), 8'(dco_pkg::MAX_SRC_DIM)));
        cfg.src_h = dco_pkg::DIM_W'(clamp_reg(8'(r_src_height), 8'(dco_pkg::MAX_SRC_DIM)));
        cfg.ic_n  = dco_pkg::ICN_W'(clamp_reg(8'(r_in_channels), 8'(dco_pkg::MAX_IN_CH)));
        cfg.oc_n  = dco_pkg::OCN_W'(clamp_reg(8'(r_out_channels), 8'(dco_pkg::MAX_OUT_CH)));
        cfg.kh    = dco_pkg::KER_W'(clamp_reg(8'(r_kernel_h), 8'(dco_pkg::MAX_KERNEL)));
        cfg.kw    = dco_pkg::KER_W'(clamp_reg(8'(r_kernel_w), 8'(dco_pkg::MAX_KERNEL)));
        cfg.sv    = dco_pkg::STR_W'(clamp_reg(8'(r_stride_v), 8'(dco_pkg::STRIDE_MAX)));
        cfg.sh    = dco_pkg::STR_W'(clamp_reg(8'(r_stride_h), 8'(dco_pkg::STRIDE_MAX)));
    end

    // sequencer
    dco_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // stores, address walk and mac
    dco_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_address     (i_address),
        .i_value       (i_value),
        .i_out_channel (i_out_channel),
        .i_out_row     (i_out_row),
        .i_out_col     (i_out_col),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_out_sum     (o_out_sum),
        .o_bad_request (o_bad_request)
    );

`ifndef SYNTHESIS
    // a result is a single-cycle strobe
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // loads complete in the cycle they are taken
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type != dco_pkg::REQ_COMPUTE)) |=> !busy)
        else $error("load transaction raised busy");

    // a compute transaction occupies the block
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == dco_pkg::REQ_COMPUTE)) |=> busy)
        else $error("compute transaction did not raise busy");

    // a flagged position carries a zero sum
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_request) |-> (o_out_sum == '0))
        else $error("bad position with non-zero sum");

    // no result while a compute is still in flight
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule

// ===== bench/direct_conv2d_output_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// direct_conv2d_output_core_test
// self-checking bench for the direct 2d convolution output core
// ============================================================================
// Fills the sample, weight and bias stores through load transactions and
// asks for single output positions through compute transactions. A
// behavioural model of the convolution runs alongside the core. Each accepted
// compute transaction pushes its expected sum and bad flag onto a queue. A
// monitor compares every result strobe with the head of that queue. Before
// any compute, the bench loads every store entry that the position will read
// and that has not been written yet. Directed tests cover register access,
// store bounds and value extremes, flagged positions and register saturation.
// A long random run then goes through many register settings with command
// gaps, ending with a stretch at full rate.
// ============================================================================
module direct_conv2d_output_core_test;

    typedef struct packed {
        logic [dco_pkg::SUM_W-1:0] sum;
        logic                      bad;
    } t_conv_result;

    localparam int RANDOM_ITEMS = 1230;

    // clock, reset and core ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [dco_pkg::REQ_W-1:0]     i_req_type;
    logic [dco_pkg::ADDR_W-1:0]    i_address;
    logic [dco_pkg::VAL_W-1:0]     i_value;
    logic [dco_pkg::OC_W-1:0]      i_out_channel;
    logic [dco_pkg::POS_W-1:0]     i_out_row;
    logic [dco_pkg::POS_W-1:0]     i_out_col;
    logic                          o_valid;
    logic [dco_pkg::SUM_W-1:0]     o_out_sum;
    logic                          o_bad_request;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dco_pkg::PADDR_W-1:0]   paddr;
    logic [dco_pkg::PDATA_W-1:0]   pwdata;
    logic [dco_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // model state: raw register codes and the three stores with written flags
    logic [dco_pkg::DIM_W-1:0]     cfg_code [8];
    logic [dco_pkg::VAL_W-1:0]     sample_mem [dco_pkg::SRC_DEPTH];
    bit                            sample_set [dco_pkg::SRC_DEPTH];
    logic [dco_pkg::VAL_W-1:0]     weight_mem [dco_pkg::WGT_DEPTH];
    bit                            weight_set [dco_pkg::WGT_DEPTH];
    logic [dco_pkg::VAL_W-1:0]     bias_mem [dco_pkg::MAX_OUT_CH];
    bit                            bias_set [dco_pkg::MAX_OUT_CH];

    t_conv_result         pending_sums [$];
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    bit                   gaps_on = 1'b1;

    direct_conv2d_output_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_value       (i_value),
        .i_out_channel (i_out_channel),
        .i_out_row     (i_out_row),
        .i_out_col     (i_out_col),
        .o_valid       (o_valid),
        .o_out_sum     (o_out_sum),
        .o_bad_request (o_bad_request),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // register model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] reg_mask(input logic [dco_pkg::REGIDX_W-1:0] idx);
        case (idx)
            dco_pkg::REG_SRC_WIDTH, dco_pkg::REG_SRC_HEIGHT:
                return (32'd1 << dco_pkg::DIM_W) - 1;
            dco_pkg::REG_IN_CHANNELS:  return (32'd1 << dco_pkg::ICN_W) - 1;
            dco_pkg::REG_OUT_CHANNELS: return (32'd1 << dco_pkg::OCN_W) - 1;
            dco_pkg::REG_KERNEL_H, dco_pkg::REG_KERNEL_W:
                return (32'd1 << dco_pkg::KER_W) - 1;
            default:                   return (32'd1 << dco_pkg::STR_W) - 1;
        endcase
    endfunction

    // value in use: the raw code saturated into [1, limit]
    function automatic int unsigned eff_reg(input logic [dco_pkg::REGIDX_W-1:0] idx);
        int unsigned code;
        int unsigned hi;
        code = cfg_code[idx];
        case (idx)
            dco_pkg::REG_SRC_WIDTH, dco_pkg::REG_SRC_HEIGHT: hi = dco_pkg::MAX_SRC_DIM;
            dco_pkg::REG_IN_CHANNELS:                        hi = dco_pkg::MAX_IN_CH;
            dco_pkg::REG_OUT_CHANNELS:                       hi = dco_pkg::MAX_OUT_CH;
            dco_pkg::REG_KERNEL_H, dco_pkg::REG_KERNEL_W:    hi = dco_pkg::MAX_KERNEL;
            default:                                         hi = dco_pkg::STRIDE_MAX;
        endcase
        if (code < 1) return 1;
        if (code > hi) return hi;
        return code;
    endfunction

    // output plane extent in one direction, zero when the kernel overhangs
    function automatic int unsigned plane_size(input int unsigned src, input int unsigned k,
                                               input int unsigned s);
        if (k > src) return 0;
        return (src - k) / s + 1;
    endfunction

    function automatic int unsigned out_rows();
        return plane_size(eff_reg(dco_pkg::REG_SRC_HEIGHT), eff_reg(dco_pkg::REG_KERNEL_H),
                          eff_reg(dco_pkg::REG_STRIDE_V));
    endfunction

    function automatic int unsigned out_cols();
        return plane_size(eff_reg(dco_pkg::REG_SRC_WIDTH), eff_reg(dco_pkg::REG_KERNEL_W),
                          eff_reg(dco_pkg::REG_STRIDE_H));
    endfunction

    function automatic bit position_ok(input int unsigned oc, input int unsigned row,
                                       input int unsigned col);
        return oc < eff_reg(dco_pkg::REG_OUT_CHANNELS) && row < out_rows() && col < out_cols();
    endfunction

    // ------------------------------------------------------------------------
    // convolution model: bias scaled to q.16 plus every sample-weight product
    // ------------------------------------------------------------------------
    function automatic t_conv_result conv_at(input int unsigned oc, input int unsigned row,
                                             input int unsigned col);
        t_conv_result res;
        int unsigned  w, h, icn, kh, kw, sv, sh, ic, r, c, si, wi;
        longint       acc;
        res.sum = '0;
        res.bad = 1'b1;
        if (!position_ok(oc, row, col)) return res;
        w   = eff_reg(dco_pkg::REG_SRC_WIDTH);
        h   = eff_reg(dco_pkg::REG_SRC_HEIGHT);
        icn = eff_reg(dco_pkg::REG_IN_CHANNELS);
        kh  = eff_reg(dco_pkg::REG_KERNEL_H);
        kw  = eff_reg(dco_pkg::REG_KERNEL_W);
        sv  = eff_reg(dco_pkg::REG_STRIDE_V);
        sh  = eff_reg(dco_pkg::REG_STRIDE_H);
        acc = longint'($signed(bias_mem[oc])) * 256;
        for (ic = 0; ic < icn; ic++) begin
            for (r = 0; r < kh; r++) begin
                for (c = 0; c < kw; c++) begin
                    si  = ic * h * w + (row * sv + r) * w + col * sh + c;
                    wi  = oc * icn * kh * kw + ic * kh * kw + r * kw + c;
                    acc += longint'($signed(sample_mem[si])) * longint'($signed(weight_mem[wi]));
                end
            end
        end
        res.sum = acc[dco_pkg::SUM_W-1:0];
        res.bad = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    function automatic logic [dco_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return dco_pkg::VAL_W'($urandom());
        endcase
    endfunction

    // one transaction: optional idle burst, then hold start until busy is low
    task automatic send_item(input logic [dco_pkg::REQ_W-1:0] req,
                             input logic [dco_pkg::ADDR_W-1:0] addr,
                             input logic [dco_pkg::VAL_W-1:0] val,
                             input logic [dco_pkg::OC_W-1:0] oc,
                             input logic [dco_pkg::POS_W-1:0] row,
                             input logic [dco_pkg::POS_W-1:0] col);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_req_type    <= dco_pkg::REQ_W'($urandom());
            i_address     <= dco_pkg::ADDR_W'($urandom());
            i_value       <= dco_pkg::VAL_W'($urandom());
            i_out_channel <= dco_pkg::OC_W'($urandom());
            i_out_row     <= dco_pkg::POS_W'($urandom());
            i_out_col     <= dco_pkg::POS_W'($urandom());
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= req;
        i_address     <= addr;
        i_value       <= val;
        i_out_channel <= oc;
        i_out_row     <= row;
        i_out_col     <= col;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        // accepted at this edge: apply it to the model
        case (req)
            dco_pkg::REQ_LD_SRC: begin
                if (int'(addr) < dco_pkg::SRC_DEPTH) begin
                    sample_mem[addr] = val;
                    sample_set[addr] = 1'b1;
                end
            end
            dco_pkg::REQ_LD_WGT: begin
                if (int'(addr) < dco_pkg::WGT_DEPTH) begin
                    weight_mem[addr] = val;
                    weight_set[addr] = 1'b1;
                end
            end
            dco_pkg::REQ_LD_BIAS: begin
                if (int'(addr) < dco_pkg::MAX_OUT_CH) begin
                    bias_mem[addr] = val;
                    bias_set[addr] = 1'b1;
                end
            end
            default: begin
                pending_sums.insert(pending_sums.size(), conv_at(oc, row, col));
            end
        endcase
    endtask

    task automatic load_entry(input logic [dco_pkg::REQ_W-1:0] req, input int unsigned addr,
                              input logic [dco_pkg::VAL_W-1:0] val);
        send_item(req, dco_pkg::ADDR_W'(addr), val, dco_pkg::OC_W'($urandom()),
                  dco_pkg::POS_W'($urandom()), dco_pkg::POS_W'($urandom()));
    endtask

    // compute one position, first loading whatever it reads that is still unwritten
    task automatic compute_at(input int unsigned oc, input int unsigned row,
                              input int unsigned col);
        int unsigned w, h, icn, kh, kw, sv, sh, ic, r, c, si, wi;
        if (position_ok(oc, row, col)) begin
            w   = eff_reg(dco_pkg::REG_SRC_WIDTH);
            h   = eff_reg(dco_pkg::REG_SRC_HEIGHT);
            icn = eff_reg(dco_pkg::REG_IN_CHANNELS);
            kh  = eff_reg(dco_pkg::REG_KERNEL_H);
            kw  = eff_reg(dco_pkg::REG_KERNEL_W);
            sv  = eff_reg(dco_pkg::REG_STRIDE_V);
            sh  = eff_reg(dco_pkg::REG_STRIDE_H);
            for (ic = 0; ic < icn; ic++) begin
                for (r = 0; r < kh; r++) begin
                    for (c = 0; c < kw; c++) begin
                        si = ic * h * w + (row * sv + r) * w + col * sh + c;
                        wi = oc * icn * kh * kw + ic * kh * kw + r * kw + c;
                        if (!sample_set[si]) load_entry(dco_pkg::REQ_LD_SRC, si, rand_value());
                        if (!weight_set[wi]) load_entry(dco_pkg::REQ_LD_WGT, wi, rand_value());
                    end
                end
            end
            if (!bias_set[oc]) load_entry(dco_pkg::REQ_LD_BIAS, oc, rand_value());
        end
        send_item(dco_pkg::REQ_COMPUTE, dco_pkg::ADDR_W'($urandom()),
                  dco_pkg::VAL_W'($urandom()), dco_pkg::OC_W'(oc),
                  dco_pkg::POS_W'(row), dco_pkg::POS_W'(col));
    endtask

    // stop issuing and wait until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sums.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic write, input logic [dco_pkg::REGIDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register with junk above its width, then read it back
    task automatic write_reg(input logic [dco_pkg::REGIDX_W-1:0] idx, input int unsigned code);
        logic [31:0] data;
        logic [31:0] readback;
        data = ($urandom() & ~reg_mask(idx)) | (code & reg_mask(idx));
        apb_access(1'b1, idx, data, readback);
        cfg_code[idx] = dco_pkg::DIM_W'(data & reg_mask(idx));
        apb_access(1'b0, idx, $urandom(), readback);
        if (readback !== (data & reg_mask(idx))) begin
            report_mismatch("register readback", readback, data & reg_mask(idx));
        end
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h,
                              input int unsigned icn, input int unsigned ocn,
                              input int unsigned kh, input int unsigned kw,
                              input int unsigned sv, input int unsigned sh);
        drain_results();
        write_reg(dco_pkg::REG_SRC_WIDTH, w);
        write_reg(dco_pkg::REG_SRC_HEIGHT, h);
        write_reg(dco_pkg::REG_IN_CHANNELS, icn);
        write_reg(dco_pkg::REG_OUT_CHANNELS, ocn);
        write_reg(dco_pkg::REG_KERNEL_H, kh);
        write_reg(dco_pkg::REG_KERNEL_W, kw);
        write_reg(dco_pkg::REG_STRIDE_V, sv);
        write_reg(dco_pkg::REG_STRIDE_H, sh);
    endtask

    // ------------------------------------------------------------------------
    // result monitor: one strobe, one expectation, compared field by field
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_conv_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("result with nothing pending", o_out_sum, 0);
            end else begin
                want = pending_sums.pop_front();
                if (o_out_sum !== want.sum) report_mismatch("out_sum", o_out_sum, want.sum);
                if (o_bad_request !== want.bad) begin
                    report_mismatch("bad_request", o_bad_request, want.bad);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values read back, then every register written and read
    task automatic test_register_access();
        logic [31:0] readback;
        logic [dco_pkg::REGIDX_W-1:0] idx;
        int i;
        for (i = 0; i < 8; i++) begin
            idx = dco_pkg::REGIDX_W'(i);
            apb_access(1'b0, idx, $urandom(), readback);
            if (readback !== 32'(cfg_code[idx])) begin
                report_mismatch("reset value", readback, cfg_code[idx]);
            end
        end
        set_config(33, 17, 3, 9, 5, 2, 6, 11);
    endtask

    // value extremes at both ends of the stores, and loads past the weight and bias stores
    task automatic test_store_bounds();
        set_config(64, 64, 4, 16, 1, 1, 1, 1);
        load_entry(dco_pkg::REQ_LD_SRC, dco_pkg::SRC_DEPTH - 1, 16'h8000);
        load_entry(dco_pkg::REQ_LD_SRC, 0, 16'h7fff);
        load_entry(dco_pkg::REQ_LD_WGT, 63, 16'h8000);
        load_entry(dco_pkg::REQ_LD_WGT, 0, 16'h7fff);
        load_entry(dco_pkg::REQ_LD_WGT, dco_pkg::WGT_DEPTH - 1, 16'h0000);
        // past the end of the store: must be dropped, not wrapped
        load_entry(dco_pkg::REQ_LD_WGT, dco_pkg::WGT_DEPTH, 16'h1234);
        load_entry(dco_pkg::REQ_LD_WGT, 16383, 16'hffff);
        load_entry(dco_pkg::REQ_LD_BIAS, dco_pkg::MAX_OUT_CH - 1, 16'h7fff);
        load_entry(dco_pkg::REQ_LD_BIAS, 0, 16'h8000);
        load_entry(dco_pkg::REQ_LD_BIAS, dco_pkg::MAX_OUT_CH, 16'h5555);
        load_entry(dco_pkg::REQ_LD_BIAS, 16383, 16'haaaa);
        // last position of the last channel reads the top sample address
        compute_at(15, 63, 63);
        compute_at(0, 0, 0);
    endtask

    // channel, row and column each just out of range, then a kernel overhang in each direction
    task automatic test_bad_positions();
        set_config(10, 7, 1, 3, 3, 2, 2, 3);
        compute_at(3, 0, 0);
        compute_at(2, 3, 0);
        compute_at(2, 0, 3);
        compute_at(15, 63, 63);
        compute_at(2, 2, 2);
        drain_results();
        write_reg(dco_pkg::REG_KERNEL_H, 9);
        compute_at(0, 0, 0);
        drain_results();
        write_reg(dco_pkg::REG_KERNEL_H, 3);
        write_reg(dco_pkg::REG_KERNEL_W, 11);
        compute_at(0, 0, 0);
    endtask

    // zero codes act as one, codes above the limit act as the limit
    task automatic test_register_saturation();
        set_config(0, 0, 0, 0, 0, 0, 0, 0);
        compute_at(0, 0, 0);
        compute_at(0, 0, 1);
        compute_at(0, 1, 0);
        compute_at(1, 0, 0);
        // 64 source, 11 kernel, stride 16 gives a 4 by 4 plane
        set_config(127, 127, 7, 31, 15, 15, 31, 31);
        compute_at(15, 4, 3);
        compute_at(15, 3, 4);
        compute_at(0, 63, 63);
    endtask

    function automatic int unsigned pick_kernel_code();
        if ($urandom_range(0, 5) == 0) return $urandom_range(12, 15);
        return $urandom_range(0, 4);
    endfunction

    // many register settings, each followed by a mix of computes and loads
    task automatic test_random_phases();
        int          random_end, phase_no, budget, phase_start, choice;
        int unsigned ocn, oh, ow, kh, kw, icn;
        random_end = items_sent + RANDOM_ITEMS;
        phase_no   = 0;
        while (items_sent < random_end) begin
            gaps_on = 1'b1;
            if (phase_no == 0) begin
                // largest kernel over the full source with the widest strides
                set_config(127, 64, 1, $urandom_range(1, 16), 11, 14, 16, 31);
            end else if (phase_no == 1) begin
                // all channels in use
                set_config(64, 127, 7, 31, 2, 2, $urandom_range(1, 3), $urandom_range(1, 3));
            end else if ($urandom_range(0, 3) == 0) begin
                // full code range; big kernels only with a single channel
                kh  = pick_kernel_code();
                kw  = pick_kernel_code();
                icn = (kh > 4 || kw > 4) ? $urandom_range(0, 1) : $urandom_range(0, 7);
                set_config($urandom_range(0, 127), $urandom_range(0, 127), icn,
                           $urandom_range(0, 31), kh, kw, $urandom_range(0, 31),
                           $urandom_range(0, 31));
            end else begin
                set_config($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4),
                           $urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 4),
                           $urandom_range(1, 4), $urandom_range(1, 4));
            end
            phase_no++;
            budget      = $urandom_range(50, 110);
            phase_start = items_sent;
            ocn = eff_reg(dco_pkg::REG_OUT_CHANNELS);
            oh  = out_rows();
            ow  = out_cols();
            while (items_sent - phase_start < budget && items_sent < random_end) begin
                // the closing stretch runs back to back
                gaps_on = (random_end - items_sent > 150);
                choice  = $urandom_range(0, 99);
                if (choice < 45 && oh > 0 && ow > 0) begin
                    compute_at($urandom_range(0, ocn - 1), $urandom_range(0, oh - 1),
                               $urandom_range(0, ow - 1));
                end else if (choice < 60) begin
                    compute_at($urandom_range(0, 15), $urandom_range(0, 63),
                               $urandom_range(0, 63));
                end else if (choice < 85) begin
                    // fresh values inside the region the current setting reads
                    case ($urandom_range(0, 2))
                        0: load_entry(dco_pkg::REQ_LD_SRC,
                                      $urandom_range(0, eff_reg(dco_pkg::REG_IN_CHANNELS)
                                      * eff_reg(dco_pkg::REG_SRC_HEIGHT)
                                      * eff_reg(dco_pkg::REG_SRC_WIDTH) - 1),
                                      rand_value());
                        1: load_entry(dco_pkg::REQ_LD_WGT,
                                      $urandom_range(0, ocn * eff_reg(dco_pkg::REG_IN_CHANNELS)
                                      * eff_reg(dco_pkg::REG_KERNEL_H)
                                      * eff_reg(dco_pkg::REG_KERNEL_W) - 1),
                                      rand_value());
                        default: load_entry(dco_pkg::REQ_LD_BIAS, $urandom_range(0, ocn - 1),
                                            rand_value());
                    endcase
                end else begin
                    load_entry(dco_pkg::REQ_W'($urandom_range(0, 2)),
                               dco_pkg::ADDR_W'($urandom()), rand_value());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        start         = 1'b0;
        i_req_type    = dco_pkg::REQ_LD_SRC;
        i_address     = '0;
        i_value       = '0;
        i_out_channel = '0;
        i_out_row     = '0;
        i_out_col     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_rst_n       = 1'b0;
        cfg_code[dco_pkg::REG_SRC_WIDTH]    = 7'd64;
        cfg_code[dco_pkg::REG_SRC_HEIGHT]   = 7'd64;
        cfg_code[dco_pkg::REG_IN_CHANNELS]  = 7'd1;
        cfg_code[dco_pkg::REG_OUT_CHANNELS] = 7'd1;
        cfg_code[dco_pkg::REG_KERNEL_H]     = 7'd3;
        cfg_code[dco_pkg::REG_KERNEL_W]     = 7'd3;
        cfg_code[dco_pkg::REG_STRIDE_V]     = 7'd1;
        cfg_code[dco_pkg::REG_STRIDE_H]     = 7'd1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_store_bounds();
        test_bad_positions();
        test_register_saturation();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== direct_conv2d_output_core.f =====
sv/dco_pkg.sv
sv/dco_ram.sv
sv/dco_ctrl.sv
sv/dco_dp.sv
sv/direct_conv2d_output_core.sv
bench/direct_conv2d_output_core_test.sv
